// File: src/etw_pkg.sv
// Shared types, constants and the elastic curve table for the tween engine.
package etw_pkg;

  localparam int FracBits     = 16;
  localparam int ElasticDepth = 1024;
  localparam int RomIdxW      = $clog2(ElasticDepth);
  localparam int XW           = FracBits;
  localparam int CurveW       = FracBits + 4;
  localparam int MulW         = FracBits + 8;
  localparam int ProdW        = 2 * MulW;
  localparam int BounceShift  = FracBits + 6;
  localparam int DivSteps     = FracBits;
  localparam int DivCntW      = $clog2(DivSteps);
  localparam int CurveSteps   = 4;
  localparam int StepW        = 2;
  localparam int ValW         = 16;
  localparam int TimeW        = 32;
  localparam int CfgW         = 3;

  localparam longint QOne    = longint'(1) << FracBits;
  localparam longint QHalf   = QOne / 2;
  localparam longint Q30One  = longint'(1) << 30;
  localparam longint Q30Div  = longint'(1) << (30 - FracBits);
  localparam longint BackC1  = longint'(1827057613) / Q30Div;
  localparam longint BackC3  = BackC1 + QOne;
  localparam longint BounceAdd1 = (3 * QOne) / 4;
  localparam longint BounceAdd2 = (15 * QOne) / 16;
  localparam longint BounceAdd3 = (63 * QOne) / 64;
  localparam longint ValueMax = 32767;
  localparam longint ValueMinMag = 32768;

  localparam logic [2:0] CurveNone       = 3'd0;
  localparam logic [2:0] CurveOutBack    = 3'd1;
  localparam logic [2:0] CurveInOutQuart = 3'd2;
  localparam logic [2:0] CurveOutQuint   = 3'd3;
  localparam logic [2:0] CurveOutElastic = 3'd4;
  localparam logic [2:0] CurveOutBounce  = 3'd5;

  localparam logic CfgCurve      = 1'b0;
  localparam logic CfgCumulative = 1'b1;

  typedef enum logic [1:0] {
    CmdTick   = 2'd0,
    CmdStart  = 2'd1,
    CmdFinish = 2'd2,
    CmdStop   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OpNone       = 4'd0,
    OpLoad       = 4'd1,
    OpDivInit    = 4'd2,
    OpDivStep    = 4'd3,
    OpCurveStep  = 4'd4,
    OpCurveFin   = 4'd5,
    OpScale      = 4'd6,
    OpRound      = 4'd7,
    OpEmitFinal  = 4'd8,
    OpEmitTick   = 4'd9,
    OpStartApply = 4'd10,
    OpStop       = 4'd11
  } dp_op_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [TimeW-1:0]        now_ms;
    logic signed [ValW-1:0]  move_distance;
    logic [ValW-1:0]         move_duration;
  } in_item_t;

  typedef struct packed {
    dp_op_e           op;
    logic [StepW-1:0] step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic running;
    logic expired;
    logic cumulative;
    logic out_free;
    cmd_e command;
  } status_t;

  typedef logic signed [CurveW-1:0] rom_t [ElasticDepth];

  localparam longint ExpCoef [7] = '{
    1073741824, -744261118, 257941251, -59597084, 10327388, -1431684, 165399
  };
  localparam longint SinA = 1686629713;
  localparam longint SinB = 693598564;
  localparam longint SinC = 85569278;
  localparam longint SinD = 5027044;
  localparam longint PhaseOff = 805306368;

  function automatic longint mul30(longint a, longint b);
    return (a * b) / Q30One;
  endfunction

  // 2^(-10t) * sin(2pi(10t - 0.75)/3) + 1, Q30 then cut to the Q format
  function automatic logic signed [CurveW-1:0] elastic_entry(int idx);
    longint t, y, n, f, e, ph, m, q, z, z2, s, r;
    t = (longint'(idx) <<< 30) / ElasticDepth;
    y = 10 * t;
    n = y / Q30One;
    f = y % Q30One;
    e = ExpCoef[6];
    for (int k = 5; k >= 0; k--) begin
      e = ExpCoef[k] + mul30(e, f);
    end
    e = e >>> (n & 15);
    ph = (y - PhaseOff) / 3;
    m = ph % Q30One;
    if (m < 0) m = m + Q30One;
    q = (m >= (Q30One >>> 1)) ? m - Q30One : m;
    if (q > (Q30One >>> 2)) begin
      q = (Q30One >>> 1) - q;
    end else if (q < -(Q30One >>> 2)) begin
      q = -(Q30One >>> 1) - q;
    end
    z  = 4 * q;
    z2 = mul30(z, z);
    s  = mul30(z, SinA - mul30(z2, SinB - mul30(z2, SinC - mul30(z2, SinD))));
    r  = (mul30(e, s) + Q30One) / Q30Div;
    return CurveW'(r);
  endfunction

  function automatic rom_t build_elastic_rom();
    rom_t rom;
    for (int i = 0; i < ElasticDepth; i++) begin
      rom[i] = elastic_entry(i);
    end
    return rom;
  endfunction

  localparam rom_t ElasticRom = build_elastic_rom();

endpackage

// File: src/etw_in_if.sv
// Command channel: valid/ready handshake with the command item fields.
interface etw_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [etw_pkg::TimeW-1:0]           now_ms;
  logic signed [etw_pkg::ValW-1:0]     move_distance;
  logic [etw_pkg::ValW-1:0]            move_duration;

  modport source (output valid, command, now_ms, move_distance, move_duration,
                  input ready);
  modport sink   (input valid, command, now_ms, move_distance, move_duration,
                  output ready);
endinterface

// File: src/etw_out_if.sv
// Result channel: valid/ready handshake with the result item fields.
interface etw_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [etw_pkg::ValW-1:0] value;
  logic                            finished;

  modport source (output valid, value, finished, input ready);
  modport sink   (input valid, value, finished, output ready);
endinterface

// File: src/etw_ctrl.sv
// Sequencer that steps the tween datapath through one command at a time.
module etw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  etw_pkg::status_t    status_i,
  output etw_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    StIdle      = 10'b0000000001,
    StDecide    = 10'b0000000010,
    StDiv       = 10'b0000000100,
    StCurve     = 10'b0000001000,
    StCurveFin  = 10'b0000010000,
    StScale     = 10'b0000100000,
    StRound     = 10'b0001000000,
    StEmitFinal = 10'b0010000000,
    StEmitTick  = 10'b0100000000,
    StStart     = 10'b1000000000
  } state_e;

  state_e                       state_q, state_d;
  logic [etw_pkg::DivCntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o.op   = etw_pkg::OpNone;
    cmd_o.step = cnt_q[etw_pkg::StepW-1:0];
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = etw_pkg::OpLoad;
          state_d  = StDecide;
        end
      end
      StDecide: begin
        cnt_d = '0;
        unique case (status_i.command)
          etw_pkg::CmdTick: begin
            if (!status_i.running) begin
              state_d = StIdle;
            end else if (status_i.expired) begin
              state_d = StEmitFinal;
            end else begin
              cmd_o.op = etw_pkg::OpDivInit;
              state_d  = StDiv;
            end
          end
          etw_pkg::CmdStart: begin
            // cumulative retarget needs the position a tick would give now
            if (status_i.running && status_i.cumulative && !status_i.expired) begin
              cmd_o.op = etw_pkg::OpDivInit;
              state_d  = StDiv;
            end else begin
              state_d = StStart;
            end
          end
          etw_pkg::CmdFinish: begin
            state_d = status_i.running ? StEmitFinal : StIdle;
          end
          etw_pkg::CmdStop: begin
            cmd_o.op = etw_pkg::OpStop;
            state_d  = StIdle;
          end
          default: state_d = StIdle;
        endcase
      end
      StDiv: begin
        cmd_o.op = etw_pkg::OpDivStep;
        if (cnt_q == etw_pkg::DivCntW'(etw_pkg::DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = StCurve;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StCurve: begin
        cmd_o.op = etw_pkg::OpCurveStep;
        if (cnt_q[etw_pkg::StepW-1:0] == etw_pkg::StepW'(etw_pkg::CurveSteps - 1)) begin
          cnt_d   = '0;
          state_d = StCurveFin;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StCurveFin: begin
        cmd_o.op = etw_pkg::OpCurveFin;
        state_d  = StScale;
      end
      StScale: begin
        cmd_o.op = etw_pkg::OpScale;
        state_d  = StRound;
      end
      StRound: begin
        cmd_o.op = etw_pkg::OpRound;
        state_d  = (status_i.command == etw_pkg::CmdStart) ? StStart : StEmitTick;
      end
      StEmitFinal: begin
        if (status_i.out_free) begin
          cmd_o.op = etw_pkg::OpEmitFinal;
          state_d  = StIdle;
        end
      end
      StEmitTick: begin
        if (status_i.out_free) begin
          cmd_o.op = etw_pkg::OpEmitTick;
          state_d  = StIdle;
        end
      end
      StStart: begin
        cmd_o.op = etw_pkg::OpStartApply;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: src/etw_datapath.sv
// Tween datapath: state, divider, shared multiplier, curves, rounding, output register.
module etw_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  etw_pkg::ctrl_cmd_t               cmd_i,
  output etw_pkg::status_t                 status_o,
  input  etw_pkg::in_item_t                in_item_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [etw_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [etw_pkg::ValW-1:0]  out_value_o,
  output logic                             out_finished_o
);

  localparam int MulW   = etw_pkg::MulW;
  localparam int ProdW  = etw_pkg::ProdW;
  localparam int CurveW = etw_pkg::CurveW;
  localparam int ValW   = etw_pkg::ValW;
  localparam int XW     = etw_pkg::XW;

  // configuration and animation state
  logic [2:0]                  curve_q;
  logic                        cum_q;
  logic                        running_q;
  logic [etw_pkg::TimeW-1:0]   start_q;
  logic [ValW-1:0]             span_q;
  logic [ValW-1:0]             total_q;
  logic [ValW-1:0]             emitted_q;

  // captured command
  etw_pkg::cmd_e               cmd_q;
  logic [etw_pkg::TimeW-1:0]   now_q;
  logic [ValW-1:0]             dist_q;
  logic [ValW-1:0]             dur_q;

  // working registers
  logic [ValW-1:0]             rem_q;
  logic [XW-1:0]               x_q;
  logic signed [CurveW-1:0]    r_q [3];
  logic signed [CurveW-1:0]    rom_q;
  logic signed [CurveW-1:0]    curve_val_q;
  logic signed [ProdW-1:0]     full_q;
  logic [ValW-1:0]             expected_q;

  logic                        out_valid_q;
  logic [ValW-1:0]             out_value_q;
  logic                        out_fin_q;

  logic [etw_pkg::TimeW-1:0]   elapsed;
  logic                        expired;
  logic                        out_free;

  assign elapsed  = now_q - start_q;
  assign expired  = (elapsed >= etw_pkg::TimeW'(span_q));
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.running    = running_q;
  assign status_o.expired    = expired;
  assign status_o.cumulative = cum_q;
  assign status_o.out_free   = out_free;
  assign status_o.command    = cmd_q;

  // restoring divider step: one quotient bit per cycle
  logic [ValW:0] rem_sh;
  logic          rem_ge;
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, span_q});

  // curve operand preparation
  logic signed [MulW-1:0] x_ext, qone_m, d_ob, w_quart, w_quint, v22, bvv;
  logic signed [CurveW-1:0] badd;
  logic                   lo_half;

  assign x_ext   = signed'(MulW'(x_q));
  assign qone_m  = MulW'(etw_pkg::QOne);
  assign d_ob    = x_ext - qone_m;
  assign lo_half = ~x_q[XW-1];
  assign w_quart = lo_half ? x_ext : (MulW'(2 * etw_pkg::QOne) - (x_ext <<< 1));
  assign w_quint = qone_m - x_ext;
  assign v22     = (x_ext <<< 4) + (x_ext <<< 2) + (x_ext <<< 1);

  always_comb begin
    priority if (v22 < MulW'(8 * etw_pkg::QOne)) begin
      bvv  = v22;
      badd = '0;
    end else if (v22 < MulW'(16 * etw_pkg::QOne)) begin
      bvv  = v22 - MulW'(12 * etw_pkg::QOne);
      badd = CurveW'(etw_pkg::BounceAdd1);
    end else if (v22 < MulW'(20 * etw_pkg::QOne)) begin
      bvv  = v22 - MulW'(18 * etw_pkg::QOne);
      badd = CurveW'(etw_pkg::BounceAdd2);
    end else begin
      bvv  = v22 - MulW'(21 * etw_pkg::QOne);
      badd = CurveW'(etw_pkg::BounceAdd3);
    end
  end

  // shared multiplier operand select
  logic signed [MulW-1:0]  op_a, op_b;
  logic                    step_we;
  logic [1:0]              step_dst;
  logic                    wide_shift;
  logic signed [MulW-1:0]  r0_m, r1_m, rt_m;

  assign r0_m = MulW'(r_q[0]);
  assign r1_m = MulW'(r_q[1]);
  assign rt_m = MulW'(signed'({1'b0, total_q}) - (total_q[ValW-1] ? (MulW'(1) <<< ValW) : '0));

  always_comb begin
    op_a       = '0;
    op_b       = '0;
    step_we    = 1'b0;
    step_dst   = 2'd0;
    wide_shift = 1'b0;
    if (cmd_i.op == etw_pkg::OpScale) begin
      op_a = MulW'(curve_val_q);
      op_b = rt_m;
    end else begin
      unique case (curve_q)
        etw_pkg::CurveOutBack: begin
          step_we = 1'b1;
          unique case (cmd_i.step)
            2'd0: begin op_a = d_ob; op_b = d_ob; step_dst = 2'd0; end
            2'd1: begin op_a = r0_m; op_b = d_ob; step_dst = 2'd1; end
            2'd2: begin
              op_a = MulW'(etw_pkg::BackC3); op_b = r1_m; step_dst = 2'd2;
            end
            default: begin
              op_a = MulW'(etw_pkg::BackC1); op_b = r0_m; step_dst = 2'd0;
            end
          endcase
        end
        etw_pkg::CurveInOutQuart: begin
          unique case (cmd_i.step)
            2'd0: begin op_a = w_quart; op_b = w_quart; step_we = 1'b1; end
            2'd1: begin op_a = r0_m; op_b = r0_m; step_we = 1'b1; step_dst = 2'd1; end
            default: step_we = 1'b0;
          endcase
        end
        etw_pkg::CurveOutQuint: begin
          unique case (cmd_i.step)
            2'd0: begin op_a = w_quint; op_b = w_quint; step_we = 1'b1; end
            2'd1: begin op_a = r0_m; op_b = r0_m; step_we = 1'b1; step_dst = 2'd1; end
            2'd2: begin op_a = r1_m; op_b = w_quint; step_we = 1'b1; step_dst = 2'd2; end
            default: step_we = 1'b0;
          endcase
        end
        etw_pkg::CurveOutBounce: begin
          if (cmd_i.step == 2'd0) begin
            op_a       = bvv;
            op_b       = bvv;
            step_we    = 1'b1;
            wide_shift = 1'b1;
          end
        end
        default: step_we = 1'b0;
      endcase
    end
  end

  logic signed [ProdW-1:0] mul_p, mul_q;
  logic signed [CurveW-1:0] step_res;

  assign mul_p = op_a * op_b;
  // Q product back to Q, truncating toward zero
  assign mul_q = mul_p[ProdW-1]
               ? ((mul_p + ProdW'(etw_pkg::QOne - 1)) >>> etw_pkg::FracBits)
               : (mul_p >>> etw_pkg::FracBits);
  assign step_res = wide_shift ? CurveW'(mul_p >>> etw_pkg::BounceShift) : CurveW'(mul_q);

  // curve value at the end of the step sequence
  logic signed [CurveW-1:0] curve_fin;
  logic signed [CurveW-1:0] qone_c;
  assign qone_c = CurveW'(etw_pkg::QOne);

  always_comb begin
    unique case (curve_q)
      etw_pkg::CurveOutBack:    curve_fin = qone_c + r_q[2] + r_q[0];
      etw_pkg::CurveInOutQuart: curve_fin = lo_half ? (r_q[1] <<< 3) : (qone_c - (r_q[1] >>> 1));
      etw_pkg::CurveOutQuint:   curve_fin = qone_c - r_q[2];
      etw_pkg::CurveOutElastic: curve_fin = (x_q == '0) ? '0 : rom_q;
      etw_pkg::CurveOutBounce:  curve_fin = r_q[0] + badd;
      default:                  curve_fin = qone_c;
    endcase
  end

  // round half away from zero and saturate
  logic [ProdW-1:0] mag, rr;
  logic [ValW-1:0]  rounded;
  assign mag = full_q[ProdW-1] ? ProdW'(-full_q) : ProdW'(full_q);
  assign rr  = (mag + ProdW'(etw_pkg::QHalf)) >> etw_pkg::FracBits;

  always_comb begin
    if (full_q[ProdW-1]) begin
      rounded = (rr > ProdW'(etw_pkg::ValueMinMag)) ? {1'b1, {(ValW-1){1'b0}}}
                                                   : ValW'(0) - rr[ValW-1:0];
    end else begin
      rounded = (rr > ProdW'(etw_pkg::ValueMax)) ? {1'b0, {(ValW-1){1'b1}}}
                                                : rr[ValW-1:0];
    end
  end

  logic [ValW-1:0] final_val, tick_val, cur_pos;
  assign final_val = cum_q ? (emitted_q + total_q) : (total_q - emitted_q);
  assign tick_val  = cum_q ? (emitted_q + expected_q) : (expected_q - emitted_q);
  assign cur_pos   = expired ? (emitted_q + total_q) : (emitted_q + expected_q);

  always_ff @(posedge clk_i) begin
    rom_q <= etw_pkg::ElasticRom[x_q[XW-1 -: etw_pkg::RomIdxW]];
    unique case (cmd_i.op)
      etw_pkg::OpLoad: begin
        cmd_q  <= etw_pkg::cmd_e'(in_item_i.command);
        now_q  <= in_item_i.now_ms;
        dist_q <= in_item_i.move_distance;
        dur_q  <= in_item_i.move_duration;
      end
      etw_pkg::OpDivInit: begin
        rem_q <= elapsed[ValW-1:0];
        x_q   <= '0;
      end
      etw_pkg::OpDivStep: begin
        rem_q <= rem_ge ? ValW'(rem_sh - {1'b0, span_q}) : rem_sh[ValW-1:0];
        x_q   <= {x_q[XW-2:0], rem_ge};
      end
      etw_pkg::OpCurveStep: begin
        if (step_we) r_q[step_dst] <= step_res;
      end
      etw_pkg::OpCurveFin: curve_val_q <= curve_fin;
      etw_pkg::OpScale:    full_q      <= mul_p;
      etw_pkg::OpRound:    expected_q  <= rounded;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q     <= etw_pkg::CurveNone;
      cum_q       <= 1'b0;
      running_q   <= 1'b0;
      start_q     <= '0;
      span_q      <= '0;
      total_q     <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == etw_pkg::CfgCurve && !running_q) curve_q <= cfg_wdata_i[2:0];
        if (cfg_idx_i == etw_pkg::CfgCumulative) cum_q <= cfg_wdata_i[0];
      end
      if (cmd_i.op == etw_pkg::OpEmitFinal || cmd_i.op == etw_pkg::OpEmitTick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        etw_pkg::OpEmitFinal: running_q <= 1'b0;
        etw_pkg::OpEmitTick: begin
          if (!cum_q) emitted_q <= expected_q;
        end
        etw_pkg::OpStop: running_q <= 1'b0;
        etw_pkg::OpStartApply: begin
          if (running_q) begin
            if (cum_q) begin
              total_q   <= total_q - (cur_pos - emitted_q) + dist_q;
              emitted_q <= cur_pos;
            end else begin
              total_q   <= total_q - emitted_q + dist_q;
              emitted_q <= '0;
            end
          end else begin
            total_q   <= dist_q;
            emitted_q <= '0;
          end
          running_q <= 1'b1;
          span_q    <= dur_q;
          start_q   <= now_q;
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == etw_pkg::OpEmitFinal) begin
      out_value_q <= final_val;
      out_fin_q   <= 1'b1;
    end else if (cmd_i.op == etw_pkg::OpEmitTick) begin
      out_value_q <= tick_val;
      out_fin_q   <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = signed'(out_value_q);
  assign out_finished_o = out_fin_q;

endmodule

// File: src/eased_tween_engine_unit.sv
// Tween engine top level: command/result channels, config port, controller and datapath.
// A tick runs decode, one divider step per quotient bit, 4 curve steps, curve finish,
// scale and round, then loads the output register, stalling while it is full. Expiring
// ticks and running finish emit after decode; stop and idle ticks end there; start, on a
// cumulative retarget, runs the tick steps before it applies. One command in flight.
// Reset (async, active low) clears config, the animation state and the output valid flag.
module eased_tween_engine_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  etw_in_if.sink                      in_i,
  etw_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [etw_pkg::CfgW-1:0]    cfg_wdata_i
);

  etw_pkg::ctrl_cmd_t ctrl_cmd;
  etw_pkg::status_t   dp_status;
  etw_pkg::in_item_t  in_item;

  assign in_item.command       = in_i.command;
  assign in_item.now_ms        = in_i.now_ms;
  assign in_item.move_distance = in_i.move_distance;
  assign in_item.move_duration = in_i.move_duration;

  etw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  etw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status),
    .in_item_i      (in_item),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_value_o    (out_o.value),
    .out_finished_o (out_o.finished)
  );

endmodule
